@@ hw/rtl/kocnt_pkg.sv @@
// shared constants, operation codes and control/status types for the
// keyed occurrence count table; no dependencies
package kocnt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_IN_W    = 16;
    localparam int COUNT_W     = 16;
    localparam int WEIGHT_W    = 32;
    localparam int OP_W        = 3;
    localparam int USED_W      = 7;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_COUNT_ONE     = 3'd0,
        OP_APPEND_COUNT  = 3'd1,
        OP_APPEND_WEIGHT = 3'd2,
        OP_MERGE_MAX     = 3'd3,
        OP_WRITE_WEIGHT  = 3'd4,
        OP_QUERY         = 3'd5,
        OP_CLEAR         = 3'd6
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic issue_read;
        logic compare;
        logic append;
        logic clear;
        logic publish;
    } kocnt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_op;
        logic first_only;
        logic need_append;
        logic clear_op;
        logic scan_end;
        logic hit;
        logic out_free;
    } kocnt_status_t;

endpackage

@@ hw/rtl/kocnt_ctrl.sv @@
// sequencer for the keyed occurrence count table: scan, compare, append, finish
// depends on kocnt_pkg
module kocnt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  kocnt_pkg::kocnt_status_t status,
    output kocnt_pkg::kocnt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMPARE,
        S_APPEND,
        S_FINISH
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_SCAN:
            begin
                if (status.search_op && !status.scan_end)
                begin
                    cmd.issue_read = 1'b1;
                end
                else if (status.clear_op)
                begin
                    cmd.clear = 1'b1;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
            end
            S_FINISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (status.search_op && !status.scan_end)
                    begin
                        state_reg <= S_COMPARE;
                    end
                    else if (status.need_append)
                    begin
                        state_reg <= S_APPEND;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_COMPARE:
                begin
                    // count_one and query stop at the first match
                    if (status.hit && status.first_only)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_APPEND:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/kocnt_dp.sv @@
// datapath of the keyed occurrence count table: entry memories, scan index,
// fill level, request registers and the result register; depends on kocnt_pkg
module kocnt_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kocnt_pkg::kocnt_cmd_t                cmd,
    output kocnt_pkg::kocnt_status_t             status,
    input  logic [kocnt_pkg::OP_W-1:0]           in_op,
    input  logic [kocnt_pkg::KEY_IN_W-1:0]       in_key,
    input  logic [kocnt_pkg::COUNT_W-1:0]        in_amount,
    input  logic [kocnt_pkg::WEIGHT_W-1:0]       in_weight,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [kocnt_pkg::OUT_DATA_W-1:0]     out_data
);

    localparam int KW = kocnt_pkg::KEY_BITS;
    localparam int AW = kocnt_pkg::ADDR_W;
    localparam int FW = kocnt_pkg::FILL_W;
    localparam int CW = kocnt_pkg::COUNT_W;
    localparam int WW = kocnt_pkg::WEIGHT_W;
    localparam int UW = kocnt_pkg::USED_W;

    logic [KW-1:0] key_mem    [kocnt_pkg::TABLE_DEPTH];
    logic [CW-1:0] count_mem  [kocnt_pkg::TABLE_DEPTH];
    logic [WW-1:0] weight_mem [kocnt_pkg::TABLE_DEPTH];

    // request registers
    logic [kocnt_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]              key_reg;
    logic [CW-1:0]              amount_reg;
    logic [WW-1:0]              weight_reg;

    // scan and result registers
    logic [FW-1:0] idx_reg;
    logic [KW-1:0] rd_key_reg;
    logic [CW-1:0] rd_count_reg;
    logic          found_reg;
    logic [CW-1:0] cnt_reg;
    logic          dropped_reg;

    logic [FW-1:0]   fill_reg, fill_next;
    logic            out_valid_reg, out_valid_next;
    logic [UW+CW+1:0] out_data_reg;

    logic          is_count_one, is_merge_max, is_weight_write, is_query;
    logic          is_append_count, is_append_weight, is_clear;
    logic          full;
    logic          hit;
    logic [AW-1:0] idx_addr, fill_addr;

    // memory write port controls
    logic          key_we, count_we, weight_we;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] count_wdata;
    logic [WW-1:0] weight_wdata;

    assign is_count_one     = (op_reg == kocnt_pkg::OP_COUNT_ONE);
    assign is_append_count  = (op_reg == kocnt_pkg::OP_APPEND_COUNT);
    assign is_append_weight = (op_reg == kocnt_pkg::OP_APPEND_WEIGHT);
    assign is_merge_max     = (op_reg == kocnt_pkg::OP_MERGE_MAX);
    assign is_weight_write  = (op_reg == kocnt_pkg::OP_WRITE_WEIGHT);
    assign is_query         = (op_reg == kocnt_pkg::OP_QUERY);
    assign is_clear         = (op_reg == kocnt_pkg::OP_CLEAR);

    assign full      = (fill_reg >= FW'(kocnt_pkg::TABLE_DEPTH));
    assign hit       = (rd_key_reg == key_reg);
    assign idx_addr  = idx_reg[AW-1:0];
    assign fill_addr = fill_reg[AW-1:0];

    always_comb
    begin
        status.search_op   = is_count_one || is_merge_max || is_weight_write || is_query;
        status.first_only  = is_count_one || is_query;
        status.need_append = is_append_count || is_append_weight
                             || ((is_count_one || is_merge_max) && !found_reg);
        status.clear_op    = is_clear;
        status.scan_end    = (idx_reg == fill_reg);
        status.hit         = hit;
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        key_we       = 1'b0;
        count_we     = 1'b0;
        weight_we    = 1'b0;
        wr_addr      = idx_addr;
        count_wdata  = rd_count_reg;
        weight_wdata = weight_reg;
        if (cmd.compare && hit)
        begin
            if (is_count_one)
            begin
                count_we    = 1'b1;
                count_wdata = (rd_count_reg == kocnt_pkg::COUNT_MAX) ? rd_count_reg
                                                                     : CW'(rd_count_reg + 1'b1);
            end
            else if (is_merge_max && (amount_reg > rd_count_reg))
            begin
                count_we    = 1'b1;
                count_wdata = amount_reg;
            end
            else if (is_weight_write)
            begin
                weight_we = 1'b1;
            end
        end
        else if (cmd.append && !full)
        begin
            wr_addr   = fill_addr;
            key_we    = 1'b1;
            count_we  = 1'b1;
            weight_we = 1'b1;
            if (is_append_count)
            begin
                count_wdata = amount_reg;
            end
            else if (is_append_weight)
            begin
                count_wdata = '0;
            end
            else
            begin
                count_wdata = CW'(1);
            end
            weight_wdata = is_append_weight ? weight_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        if (count_we)
        begin
            count_mem[wr_addr] <= count_wdata;
        end
        if (weight_we)
        begin
            weight_mem[wr_addr] <= weight_wdata;
        end
        if (cmd.issue_read)
        begin
            rd_key_reg   <= key_mem[idx_addr];
            rd_count_reg <= count_mem[idx_addr];
        end
    end

    // request and per-operation result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_op;
            key_reg     <= KW'(in_key);
            amount_reg  <= in_amount;
            weight_reg  <= in_weight;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            if (cmd.compare)
            begin
                idx_reg <= FW'(idx_reg + 1'b1);
                if (hit)
                begin
                    found_reg <= 1'b1;
                    if (is_query)
                    begin
                        cnt_reg <= rd_count_reg;
                    end
                end
            end
            if (cmd.append && full)
            begin
                dropped_reg <= 1'b1;
            end
        end
        if (cmd.publish)
        begin
            out_data_reg <= {UW'(fill_reg), dropped_reg, cnt_reg, found_reg};
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.append && !full)
        begin
            fill_next = FW'(fill_reg + 1'b1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = kocnt_pkg::OUT_DATA_W'(out_data_reg);

endmodule

@@ hw/rtl/keyed_occurrence_count_table.sv @@
// keyed occurrence count table: up to 64 (key, count, weight) entries
// searched by a sequential scan; top level joining kocnt_ctrl and kocnt_dp
// depends on kocnt_pkg
//
// usage: one request enters on the s_ stream (operation in s_tuser, key,
// amount and weight in s_tdata) and gives exactly one result on the m_
// stream (found, count, dropped flag and entry count in m_tdata).
// a request is taken only while the sequencer is idle; the scan walks the
// valid entries one at a time through the entry memory read port, reading
// each entry in the scan state and comparing it in the compare state.
//   search ops (count_one, merge_max, write_weight, query): scan the entries
//   (count_one and query stop at the first match), then append if needed
//   append ops: append only; clear and other codes: straight to finish
// the sequencer passes through idle before the next request is taken.
// results sit in an output register: a new request is accepted while the
// previous result waits, and only the final hand-off stalls on m_tready.
// reset empties the table (entry count 0) and drops any pending result;
// entry memories need no clearing.
module keyed_occurrence_count_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key[15:0], amount[31:16], weight_bits[63:32]
    input  logic [kocnt_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation[2:0]
    input  logic [kocnt_pkg::OP_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // found[0], count_out[16:1], dropped[17], used_entries[24:18], zero fill
    output logic [kocnt_pkg::OUT_DATA_W-1:0]    m_tdata
);

    kocnt_pkg::kocnt_cmd_t    cmd;
    kocnt_pkg::kocnt_status_t status;

    kocnt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kocnt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_tuser),
        .in_key    (s_tdata[15:0]),
        .in_amount (s_tdata[31:16]),
        .in_weight (s_tdata[63:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for keyed_occurrence_count_table: directed, table-full,
// backpressure and random request tests against an in-bench table predictor
// depends on kocnt_pkg and the keyed_occurrence_count_table rtl
module testbench;

    localparam logic [kocnt_pkg::OP_W-1:0]     OP_UNUSED_CODE = 3'd7;
    localparam logic [kocnt_pkg::KEY_IN_W-1:0] KEY_MASK       =
        kocnt_pkg::KEY_IN_W'((1 << kocnt_pkg::KEY_BITS) - 1);
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 2 * kocnt_pkg::TABLE_DEPTH + 60;

    typedef struct packed {
        logic                          found;
        logic [kocnt_pkg::COUNT_W-1:0] count;
        logic                          dropped;
        logic [kocnt_pkg::USED_W-1:0]  used;
    } table_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [kocnt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [kocnt_pkg::OP_W-1:0]       s_tuser = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [kocnt_pkg::OUT_DATA_W-1:0] m_tdata;

    // predictor copy of the table
    logic [kocnt_pkg::KEY_IN_W-1:0] tbl_key    [kocnt_pkg::TABLE_DEPTH];
    logic [kocnt_pkg::COUNT_W-1:0]  tbl_count  [kocnt_pkg::TABLE_DEPTH];
    logic [kocnt_pkg::WEIGHT_W-1:0] tbl_weight [kocnt_pkg::TABLE_DEPTH];
    int                             fill_level = 0;

    table_result_t                  result_q[$];
    logic [kocnt_pkg::KEY_IN_W-1:0] key_pool [8];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_start    = 1'b0;
    int fail_count    = 0;
    int requests_sent = 0;
    int results_seen  = 0;
    int hit_count     = 0;
    int drop_count    = 0;
    int peak_fill     = 0;
    int idle_cycles   = 0;

    keyed_occurrence_count_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic push_entry(input logic [kocnt_pkg::KEY_IN_W-1:0] k,
                                        input logic [kocnt_pkg::COUNT_W-1:0] c,
                                        input logic [kocnt_pkg::WEIGHT_W-1:0] w);
        if (fill_level >= kocnt_pkg::TABLE_DEPTH)
            return 1'b1;
        tbl_key[fill_level]    = k;
        tbl_count[fill_level]  = c;
        tbl_weight[fill_level] = w;
        fill_level++;
        return 1'b0;
    endfunction

    function automatic table_result_t predict_table_op(
        input logic [kocnt_pkg::OP_W-1:0]     op_code,
        input logic [kocnt_pkg::KEY_IN_W-1:0] key_in,
        input logic [kocnt_pkg::COUNT_W-1:0]  amt,
        input logic [kocnt_pkg::WEIGHT_W-1:0] w);
        table_result_t                  r;
        logic [kocnt_pkg::KEY_IN_W-1:0] k;
        int                             i;
        r = '0;
        k = key_in & KEY_MASK;
        case (kocnt_pkg::op_t'(op_code))
            kocnt_pkg::OP_COUNT_ONE:
            begin
                for (i = 0; i < fill_level; i++)
                begin
                    if (tbl_key[i] == k)
                    begin
                        if (tbl_count[i] != kocnt_pkg::COUNT_MAX)
                            tbl_count[i] = tbl_count[i] + 1'b1;
                        r.found = 1'b1;
                        break;
                    end
                end
                if (!r.found)
                    r.dropped = push_entry(k, 16'd1, '0);
            end
            kocnt_pkg::OP_APPEND_COUNT:
                r.dropped = push_entry(k, amt, '0);
            kocnt_pkg::OP_APPEND_WEIGHT:
                r.dropped = push_entry(k, '0, w);
            kocnt_pkg::OP_MERGE_MAX:
            begin
                for (i = 0; i < fill_level; i++)
                begin
                    if (tbl_key[i] == k)
                    begin
                        r.found = 1'b1;
                        if (amt > tbl_count[i])
                            tbl_count[i] = amt;
                    end
                end
                if (!r.found)
                    r.dropped = push_entry(k, 16'd1, '0);
            end
            kocnt_pkg::OP_WRITE_WEIGHT:
            begin
                for (i = 0; i < fill_level; i++)
                begin
                    if (tbl_key[i] == k)
                    begin
                        r.found = 1'b1;
                        tbl_weight[i] = w;
                    end
                end
            end
            kocnt_pkg::OP_QUERY:
            begin
                for (i = 0; i < fill_level; i++)
                begin
                    if (tbl_key[i] == k)
                    begin
                        r.found = 1'b1;
                        r.count = tbl_count[i];
                        break;
                    end
                end
            end
            kocnt_pkg::OP_CLEAR:
                fill_level = 0;
            default:
                ;
        endcase
        r.used = fill_level[kocnt_pkg::USED_W-1:0];
        return r;
    endfunction

    // one request: optional idle gap, then hold it until accepted
    task automatic send_request(input logic [kocnt_pkg::OP_W-1:0]     op_code,
                                input logic [kocnt_pkg::KEY_IN_W-1:0] key_val,
                                input logic [kocnt_pkg::COUNT_W-1:0]  amt,
                                input logic [kocnt_pkg::WEIGHT_W-1:0] w);
        table_result_t exp_res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op_code;
        s_tdata  <= {w, amt, key_val};
        do
            @(posedge clk);
        while (!s_tready);
        exp_res = predict_table_op(op_code, key_val, amt, w);
        result_q.insert(result_q.size(), exp_res);
        requests_sent++;
        if (fill_level > peak_fill)
            peak_fill = fill_level;
    endtask

    // sender pause until every outstanding result is back
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (result_q.size() != 0);
    endtask

    task automatic test_basic_ops();
        send_request(kocnt_pkg::OP_QUERY, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_COUNT_ONE, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_COUNT_ONE, 16'h0000, 16'd9, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_APPEND_COUNT, 16'hFFFF, kocnt_pkg::COUNT_MAX,
                     32'hFFFF_FFFF);
        // saturation at the top of the count range
        send_request(kocnt_pkg::OP_COUNT_ONE, 16'hFFFF, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'hFFFF, 16'd0, 32'd0);
        // duplicate key, merge raises every match
        send_request(kocnt_pkg::OP_APPEND_COUNT, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, 16'h0000, 16'd7, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, 16'h0000, 16'd3, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, 16'h1234, 16'd500, 32'd0);
        send_request(kocnt_pkg::OP_APPEND_WEIGHT, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(kocnt_pkg::OP_WRITE_WEIGHT, 16'h1234, 16'd0, 32'h0000_0000);
        send_request(kocnt_pkg::OP_WRITE_WEIGHT, 16'h5555, 16'd0, 32'h3F80_0000);
        send_request(kocnt_pkg::OP_QUERY, 16'h1234, 16'd0, 32'd0);
        // unused operation code changes nothing
        send_request(OP_UNUSED_CODE, 16'hAAAA, 16'hAAAA, 32'hAAAA_5555);
        send_request(kocnt_pkg::OP_CLEAR, 16'h0000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'hFFFF, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_APPEND_WEIGHT, 16'h5555, 16'hFFFF, 32'h3F80_0000);
        send_request(kocnt_pkg::OP_APPEND_COUNT, 16'h5555, 16'd10, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, 16'h5555, kocnt_pkg::COUNT_MAX, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'h5555, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_CLEAR, 16'hFFFF, kocnt_pkg::COUNT_MAX, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        logic [kocnt_pkg::KEY_IN_W-1:0] first_key;
        logic [kocnt_pkg::KEY_IN_W-1:0] last_key;
        int                             i;
        first_key = '0;
        last_key  = '0;
        send_request(kocnt_pkg::OP_CLEAR, 16'h0000, 16'd0, 32'd0);
        for (i = 0; i < kocnt_pkg::TABLE_DEPTH; i++)
        begin
            last_key = 16'($urandom_range(31));
            if (i == 0)
                first_key = last_key;
            send_request(kocnt_pkg::OP_APPEND_WEIGHT, last_key, 16'($urandom), $urandom);
        end
        // every kind of append is refused on a full table
        send_request(kocnt_pkg::OP_APPEND_COUNT, 16'h8000, 16'd5, 32'd0);
        send_request(kocnt_pkg::OP_APPEND_WEIGHT, 16'h8000, 16'd0, 32'h1234_5678);
        send_request(kocnt_pkg::OP_COUNT_ONE, 16'h8000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, 16'h8000, 16'd9, 32'd0);
        send_request(kocnt_pkg::OP_COUNT_ONE, first_key, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_MERGE_MAX, last_key, 16'd40, 32'd0);
        send_request(kocnt_pkg::OP_WRITE_WEIGHT, last_key, 16'd0, 32'hDEAD_0001);
        send_request(kocnt_pkg::OP_QUERY, last_key, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_QUERY, 16'h8000, 16'd0, 32'd0);
        send_request(kocnt_pkg::OP_CLEAR, 16'h0000, 16'd0, 32'd0);
    endtask

    task automatic send_random_request(input int clear_pct);
        logic [kocnt_pkg::OP_W-1:0]     op_code;
        logic [kocnt_pkg::KEY_IN_W-1:0] key_val;
        logic [kocnt_pkg::COUNT_W-1:0]  amt;
        int                             pick;
        pick = $urandom_range(99);
        if (pick < clear_pct)
            op_code = kocnt_pkg::OP_CLEAR;
        else if (pick < clear_pct + 2)
            op_code = OP_UNUSED_CODE;
        else
        begin
            pick = $urandom_range(99);
            if (pick < 28)
                op_code = kocnt_pkg::OP_COUNT_ONE;
            else if (pick < 40)
                op_code = kocnt_pkg::OP_APPEND_COUNT;
            else if (pick < 48)
                op_code = kocnt_pkg::OP_APPEND_WEIGHT;
            else if (pick < 62)
                op_code = kocnt_pkg::OP_MERGE_MAX;
            else if (pick < 74)
                op_code = kocnt_pkg::OP_WRITE_WEIGHT;
            else
                op_code = kocnt_pkg::OP_QUERY;
        end
        // mostly keys from a small pool so that searches hit
        if ($urandom_range(3) != 0)
            key_val = key_pool[3'($urandom_range(7))];
        else
            key_val = 16'($urandom);
        pick = $urandom_range(9);
        if (pick < 5)
            amt = 16'($urandom_range(20));
        else if (pick == 5)
            amt = kocnt_pkg::COUNT_MAX;
        else if (pick == 6)
            amt = kocnt_pkg::COUNT_MAX - 1'b1;
        else
            amt = 16'($urandom);
        send_request(op_code, key_val, amt, $urandom);
    endtask

    task automatic test_random_ops(input int num_requests, input int clear_pct);
        int i;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (i = 2; i < 8; i++)
            key_pool[i] = 16'($urandom);
        for (i = 0; i < num_requests; i++)
            send_random_request(clear_pct);
    endtask

    // receiver stalls the result stream long enough for the input to back up
    task automatic test_backpressure();
        int i;
        send_idle_pct = 0;
        hold_start = 1'b1;
        for (i = 0; i < 12; i++)
            send_random_request(0);
        wait_all_results();
    endtask

    // result ready: random idling, or a long hold-off when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_start)
            begin
                hold_start = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        table_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (result_q.size() == 0)
            begin
                $error("result with no request outstanding: m_tdata=%h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_res = result_q.pop_front();
                if (m_tdata[0] !== exp_res.found)
                begin
                    $error("found: expected %0d, got %0d", exp_res.found, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[16:1] !== exp_res.count)
                begin
                    $error("count_out: expected %0d, got %0d", exp_res.count, m_tdata[16:1]);
                    fail_count++;
                end
                if (m_tdata[17] !== exp_res.dropped)
                begin
                    $error("dropped: expected %0d, got %0d", exp_res.dropped, m_tdata[17]);
                    fail_count++;
                end
                if (m_tdata[24:18] !== exp_res.used)
                begin
                    $error("used_entries: expected %0d, got %0d",
                           exp_res.used, m_tdata[24:18]);
                    fail_count++;
                end
                if (exp_res.found)
                    hit_count++;
                if (exp_res.dropped)
                    drop_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 71;
        test_basic_ops();
        test_table_full();
        wait_all_results();
        test_backpressure();

        send_idle_pct = 29;
        recv_idle_pct = 71;
        test_random_ops(290, 4);
        wait_all_results();

        send_idle_pct = 71;
        recv_idle_pct = 29;
        test_random_ops(290, 1);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(290, 2);
        wait_all_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_q.size() != 0)
        begin
            $error("%0d results never arrived", result_q.size());
            fail_count++;
        end
        $display("covered %0d requests and %0d results: %0d key hits, %0d refused appends",
                 requests_sent, results_seen, hit_count, drop_count);
        $display("peak table fill %0d of %0d, with stalls on both streams", peak_fill,
                 kocnt_pkg::TABLE_DEPTH);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
